// ===== rtl/chrl_pkg.sv =====
// ----------------------------------------------------------------------------
// chrl_pkg: shared types and constants for the hash ring lookup core
// Item layouts, configuration codes and the hash constants.
// ----------------------------------------------------------------------------
package chrl_pkg;

    localparam int SLOT_W = 8;                 // address bits of the ring memory
    localparam int CNT_W  = SLOT_W + 1;        // holds a slot count up to the depth
    localparam int NODE_W = 4;
    localparam int NODES  = 1 << NODE_W;
    localparam int WANT_W = 5;

    localparam logic [CNT_W-1:0]  RING_SLOTS  = CNT_W'(1 << SLOT_W);
    localparam logic [WANT_W-1:0] REPLICA_CAP = WANT_W'(16);

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [31:0] MIX_C1    = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_C2    = 32'hC2B2_AE35;

    // configuration register indexes
    localparam logic CFG_RING_ENTRIES  = 1'b0;
    localparam logic CFG_REPLICA_COUNT = 1'b1;

    // item modes
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // result status codes
    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [7:0]        key_byte;
        logic              last_byte;
        logic [SLOT_W-1:0] slot_index;
        logic [31:0]       slot_hash;
        logic [NODE_W-1:0] slot_node;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] replica_node;
        logic [3:0]        replica_rank;
        logic [31:0]       lookup_hash;
        logic              status;
        logic              last_result;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [WANT_W-1:0] want;
    } ring_cfg_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] index;
        logic [31:0]       hash;
        logic [NODE_W-1:0] node;
    } slot_wr_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] lookup_hash;
    } key_done_t;

endpackage

// ===== rtl/chrl_hash.sv =====
// ----------------------------------------------------------------------------
// chrl_hash: key hashing unit
// FNV-1a over the key bytes, one byte a cycle while no finaliser runs, then a three-step finaliser.
// ----------------------------------------------------------------------------
module chrl_hash
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_en,
    input  logic [7:0]          key_byte,
    input  logic                last_byte,
    output logic                busy,
    output chrl_pkg::key_done_t done
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MIX1 = 2'd1;
    localparam logic [1:0] PH_MIX2 = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] mix_reg, mix_next;
    logic [31:0] prod;

    assign prod = (acc_reg ^ {24'd0, key_byte}) * chrl_pkg::FNV_PRIME;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        mix_next   = mix_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (byte_en)
                begin
                    if (last_byte)
                    begin
                        acc_next   = chrl_pkg::FNV_BASIS;
                        mix_next   = prod;
                        phase_next = PH_MIX1;
                    end
                    else
                    begin
                        acc_next = prod;
                    end
                end
            end
            PH_MIX1:
            begin
                mix_next   = (mix_reg ^ (mix_reg >> 16)) * chrl_pkg::MIX_C1;
                phase_next = PH_MIX2;
            end
            PH_MIX2:
            begin
                mix_next   = (mix_reg ^ (mix_reg >> 13)) * chrl_pkg::MIX_C2;
                phase_next = PH_FIN;
            end
            PH_FIN:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= chrl_pkg::FNV_BASIS;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
    end

    assign busy             = (phase_reg != PH_IDLE);
    assign done.valid       = (phase_reg == PH_FIN);
    assign done.lookup_hash = mix_reg ^ (mix_reg >> 16);

endmodule

// ===== rtl/chrl_ring.sv =====
// ----------------------------------------------------------------------------
// chrl_ring: ring memory with search and replica walk
// Holds the slots, binary-searches the start slot, walks for distinct nodes.
// ----------------------------------------------------------------------------
module chrl_ring
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chrl_pkg::ring_cfg_t  cfg,
    input  chrl_pkg::slot_wr_t   wr,
    input  chrl_pkg::key_done_t  key,
    output logic                 busy,
    output logic                 result_valid,
    output chrl_pkg::result_t    result
);

    localparam int SW = chrl_pkg::SLOT_W;
    localparam int CW = chrl_pkg::CNT_W;
    localparam int NW = chrl_pkg::NODE_W;
    localparam int WW = chrl_pkg::WANT_W;
    localparam int DEPTH = 1 << SW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_CMP    = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [32+NW-1:0] mem [DEPTH];
    logic [32+NW-1:0] rd_reg;
    logic             ren;
    logic [SW-1:0]    raddr;
    logic [31:0]      rd_hash;
    logic [NW-1:0]    rd_node;

    logic [2:0]              state_reg, state_next;
    logic [31:0]             kh_reg, kh_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;       // exclusive upper bound
    logic [SW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           mid_full;
    logic [SW-1:0]           slot_reg, slot_next;
    logic [CW-1:0]           issue_reg, issue_next;
    logic                    rv_reg, rv_next;
    logic [WW-1:0]           found_reg, found_next;
    logic [chrl_pkg::NODES-1:0] seen_reg, seen_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [NW-1:0]           pend_node_reg, pend_node_next;
    logic [3:0]              pend_rank_reg, pend_rank_next;
    logic                    out_valid_reg, out_valid_next;
    chrl_pkg::result_t       out_reg, out_next;

    assign rd_hash  = rd_reg[32+NW-1:NW];
    assign rd_node  = rd_reg[NW-1:0];
    assign mid_full = lo_reg + ((hi_reg - lo_reg - CW'(1)) >> 1);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.index] <= {wr.hash, wr.node};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rd_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        kh_next         = kh_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        slot_next       = slot_reg;
        issue_next      = issue_reg;
        rv_next         = 1'b0;
        found_next      = found_reg;
        seen_next       = seen_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        pend_rank_next  = pend_rank_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        ren             = 1'b0;
        raddr           = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (key.valid)
                begin
                    kh_next = key.lookup_hash;
                    if (cfg.count == '0)
                    begin
                        out_valid_next        = 1'b1;
                        out_next.replica_node = '0;
                        out_next.replica_rank = '0;
                        out_next.lookup_hash  = key.lookup_hash;
                        out_next.status       = chrl_pkg::STATUS_EMPTY;
                        out_next.last_result  = 1'b1;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = cfg.count;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ren        = 1'b1;
                    raddr      = mid_full[SW-1:0];
                    mid_next   = mid_full[SW-1:0];
                    state_next = ST_CMP;
                end
                else
                begin
                    slot_next       = (lo_reg < cfg.count) ? lo_reg[SW-1:0] : '0;
                    issue_next      = '0;
                    found_next      = '0;
                    seen_next       = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_WALK;
                end
            end
            ST_CMP:
            begin
                if (rd_hash < kh_reg)
                begin
                    lo_next = {1'b0, mid_reg} + CW'(1);
                end
                else
                begin
                    hi_next = {1'b0, mid_reg};
                end
                state_next = ST_SEARCH;
            end
            ST_WALK:
            begin
                if (found_reg == cfg.want || (issue_reg == cfg.count && !rv_reg))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    // reads run one slot ahead of the node check
                    if (issue_reg < cfg.count)
                    begin
                        ren        = 1'b1;
                        raddr      = slot_reg;
                        rv_next    = 1'b1;
                        issue_next = issue_reg + CW'(1);
                        slot_next  = ({1'b0, slot_reg} == cfg.count - CW'(1)) ?
                                     '0 : slot_reg + SW'(1);
                    end
                    if (rv_reg && !seen_reg[rd_node])
                    begin
                        seen_next       = seen_reg | (chrl_pkg::NODES'(1) << rd_node);
                        found_next      = found_reg + WW'(1);
                        pend_valid_next = 1'b1;
                        pend_node_next  = rd_node;
                        pend_rank_next  = found_reg[3:0];
                        // held back one node so the last one can carry the flag
                        if (pend_valid_reg)
                        begin
                            out_valid_next        = 1'b1;
                            out_next.replica_node = pend_node_reg;
                            out_next.replica_rank = pend_rank_reg;
                            out_next.lookup_hash  = kh_reg;
                            out_next.status       = chrl_pkg::STATUS_FOUND;
                            out_next.last_result  = 1'b0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                out_valid_next        = 1'b1;
                out_next.replica_node = pend_node_reg;
                out_next.replica_rank = pend_rank_reg;
                out_next.lookup_hash  = kh_reg;
                out_next.status       = chrl_pkg::STATUS_FOUND;
                out_next.last_result  = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rv_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            found_reg      <= '0;
            issue_reg      <= '0;
            seen_reg       <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rv_reg         <= rv_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
            issue_reg      <= issue_next;
            seen_reg       <= seen_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kh_reg        <= kh_next;
        mid_reg       <= mid_next;
        slot_reg      <= slot_next;
        pend_node_reg <= pend_node_next;
        pend_rank_reg <= pend_rank_next;
        out_reg       <= out_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== rtl/consistent_hash_ring_replica_lookup_core.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_replica_lookup_core: hash ring replica lookup
// Hashes key bytes, searches the loaded ring and returns distinct owners.
//
//   channel   ports                           direction  handshake
//   item      start, busy, item               in         start && !busy
//   result    result_valid, result            out        one-cycle strobe
//   config    cfg_we, cfg_index, cfg_data     in         cfg_we, no wait
//
// A load item or a key byte that is not last does not raise busy.
// A last key byte keeps busy high through finaliser states MIX1, MIX2 and FIN (two
// constant multiplies), then a SEARCH and a CMP state per search step on the ring memory
// port (up to 9 steps) plus a closing SEARCH, then WALK, one memory read a cycle, and FLUSH.
// busy drops in the cycle that carries the last result; results come at most one per cycle.
// Reset clears control state only; the ring memory is not cleared.
// ----------------------------------------------------------------------------
module consistent_hash_ring_replica_lookup_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  chrl_pkg::in_item_t item,
    output logic               result_valid,
    output chrl_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [chrl_pkg::CNT_W-1:0] cfg_data
);

    logic [chrl_pkg::CNT_W-1:0]  entries_reg;
    logic [chrl_pkg::WANT_W-1:0] replicas_reg;
    logic                        accept;
    logic                        hash_busy;
    logic                        ring_busy;
    chrl_pkg::key_done_t         key_done;
    chrl_pkg::ring_cfg_t         ring_cfg;
    chrl_pkg::slot_wr_t          slot_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg  <= '0;
            replicas_reg <= chrl_pkg::WANT_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                chrl_pkg::CFG_RING_ENTRIES:  entries_reg  <= cfg_data;
                chrl_pkg::CFG_REPLICA_COUNT: replicas_reg <= cfg_data[chrl_pkg::WANT_W-1:0];
                default:                     entries_reg  <= entries_reg;
            endcase
        end
    end

    always_comb
    begin
        ring_cfg.count = (entries_reg > chrl_pkg::RING_SLOTS) ?
                         chrl_pkg::RING_SLOTS : entries_reg;
        if (replicas_reg == '0)
        begin
            ring_cfg.want = chrl_pkg::WANT_W'(1);
        end
        else if (replicas_reg > chrl_pkg::REPLICA_CAP)
        begin
            ring_cfg.want = chrl_pkg::REPLICA_CAP;
        end
        else
        begin
            ring_cfg.want = replicas_reg;
        end
    end

    assign busy   = hash_busy | ring_busy;
    assign accept = start & ~busy;

    assign slot_wr.en    = accept & (item.mode == chrl_pkg::MODE_LOAD);
    assign slot_wr.index = item.slot_index;
    assign slot_wr.hash  = item.slot_hash;
    assign slot_wr.node  = item.slot_node;

    chrl_hash u_hash
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (accept & (item.mode == chrl_pkg::MODE_KEY)),
        .key_byte  (item.key_byte),
        .last_byte (item.last_byte),
        .busy      (hash_busy),
        .done      (key_done)
    );

    chrl_ring u_ring
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (ring_cfg),
        .wr           (slot_wr),
        .key          (key_done),
        .busy         (ring_busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // an empty-ring result is always the only one for its key
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == chrl_pkg::STATUS_EMPTY |-> result.last_result)
        else $error("empty-ring result without last flag");

    // a last key byte always starts a lookup
    a_last_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.mode == chrl_pkg::MODE_KEY && item.last_byte |=> busy)
        else $error("lookup not started after last key byte");

    // more results to come means the walk is still running
    a_more_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> busy)
        else $error("non-final result while idle");

    // the final result of a key closes the lookup
    a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |=> !result_valid)
        else $error("result after last result of a key");

endmodule
